@@ hdl/jldc_pkg.sv @@
// ----------------------------------------------------------------------------
// jldc_pkg
// Shared types, constants and small helpers of the Jalali date calculator.
// ----------------------------------------------------------------------------
package jldc_pkg;

  // Highest accepted year.
  localparam int unsigned MAX_YEAR = 4095;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DN_W    = 21;
  localparam int WD_W    = 3;
  localparam int WEEK_W  = 6;
  localparam int WYEAR_W = 13;
  localparam int OFF_W   = 9;   // day of year, and day of year plus weekday offset
  localparam int LT_W    = 12;  // leap test residue, below LT_MOD

  // Leap cycle stepping. The residue tracks ((e + 38) * 682) mod 2816 with
  // e = 474 + ((year - 474) mod 2820); a year is leap when it is below 682.
  localparam logic [LT_W-1:0] LT_MUL  = LT_W'(682);
  localparam logic [LT_W-1:0] LT_MOD  = LT_W'(2816);
  localparam logic [LT_W-1:0] LT_WRAP = LT_W'(770);   // step when e wraps by 2820
  localparam logic [LT_W-1:0] LT_INIT = LT_W'(1166);  // residue of year 1
  localparam logic [LT_W-1:0] E_INIT  = LT_W'(2821);  // e of year 1
  localparam logic [LT_W-1:0] E_LAST  = LT_W'(3293);  // last e before the wrap
  localparam logic [LT_W-1:0] E_FIRST = LT_W'(474);

  localparam logic [WEEK_W-1:0] WEEKS_BASE = WEEK_W'(52);
  localparam logic [2:0]        WD_THU     = 3'd3;  // zero-based index of weekday 4

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOOP = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_WEEK = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_DONE = 6'b100000
  } jldc_state_t;

  // Value below 14 reduced modulo 7.
  function automatic logic [2:0] mod7_small(input logic [3:0] v);
    logic [3:0] r;
    r = (v >= 4'd7) ? (v - 4'd7) : v;
    return r[2:0];
  endfunction

  // Quotient by 7 for values up to 371, by reciprocal multiply.
  function automatic logic [OFF_W-1:0] div7(input logic [OFF_W-1:0] v);
    logic [OFF_W+11-1:0] p;
    p = {11'd0, v} * (OFF_W + 11)'(293);
    return p[OFF_W+11-1:11];
  endfunction

  // Days of the months before the given month (1..12).
  function automatic logic [OFF_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [OFF_W-1:0] r;
    case (m)
      4'd1:    r = OFF_W'(0);
      4'd2:    r = OFF_W'(31);
      4'd3:    r = OFF_W'(62);
      4'd4:    r = OFF_W'(93);
      4'd5:    r = OFF_W'(124);
      4'd6:    r = OFF_W'(155);
      4'd7:    r = OFF_W'(186);
      4'd8:    r = OFF_W'(216);
      4'd9:    r = OFF_W'(246);
      4'd10:   r = OFF_W'(276);
      4'd11:   r = OFF_W'(306);
      4'd12:   r = OFF_W'(336);
      default: r = OFF_W'(0);
    endcase
    return r;
  endfunction

endpackage

@@ hdl/jalali_date_day_week_calc.sv @@
// ----------------------------------------------------------------------------
// jalali_date_day_week_calc
// Checks a Jalali date and gives its day number, weekday, week and week-year.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   in_*      slave       year, month, day_of_month
//   out_*     master      date_valid, day_number, weekday, week, week_year
//
// The cost of an item is set by the year loop, which adds one year length per
// cycle in a single adder while stepping the leap residue; an invalid year or
// month skips the loop. The block takes one item at a time; in_tready is high
// only while idle. A result is held on out_* until it is taken. Reset clears
// the sequencer and out_tvalid only.

module jalali_date_day_week_calc
  import jldc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // year[11:0], month[15:12], day_of_month[20:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // date_valid[0], day_number[21:1], weekday[24:22],
                                  // week[30:25], week_year[43:31]
);

  jldc_state_t state_r, state_nxt;

  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic               inv_r;

  // Year loop registers.
  logic [YEAR_W-1:0]  cnt_r;
  logic [LT_W-1:0]    e_r;
  logic [LT_W-1:0]    lt_r;
  logic [DN_W-1:0]    before_r;
  logic [2:0]         bm_r;
  logic [2:0]         bm_prev_r;
  logic               lp_r;
  logic               lp_prev_r;

  // Date arithmetic registers.
  logic               valid_r;
  logic [DN_W-1:0]    dn_r;
  logic [OFF_W-1:0]   off_r;
  logic [OFF_W-1:0]   x_r;
  logic [2:0]         f_r;
  logic [WEEK_W-1:0]  wraw_r;

  logic [47:0]        out_data_r;
  logic               out_valid_r;

  logic               accept;
  logic               leap_now;
  logic [LT_W-1:0]    lt_sum;
  logic [MONTH_W-1:0] in_month;
  logic [YEAR_W-1:0]  in_year;
  logic [DAY_W-1:0]   in_day;
  logic [DAY_W-1:0]   mlen;
  logic [OFF_W-1:0]   off_c;
  logic [2:0]         f_c;
  logic [OFF_W-1:0]   div_in;
  logic [OFF_W-1:0]   div_q;
  logic [OFF_W-1:0]   rem_full;
  logic [2:0]         wd_idx;
  logic [2:0]         fp;
  logic               w53_cur;
  logic               w53_prev;
  logic [WEEK_W-1:0]  week_f;
  logic [WYEAR_W-1:0] wyear_f;

  assign in_year  = in_tdata[11:0];
  assign in_month = in_tdata[15:12];
  assign in_day   = in_tdata[20:16];
  assign accept   = in_tvalid && in_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Leap test of the year under the loop counter, and the residue step.
  assign leap_now = (lt_r < LT_MUL);
  always_comb begin
    lt_sum = lt_r + ((e_r == E_LAST) ? LT_WRAP : LT_MUL);
    if (lt_sum >= LT_MOD) begin
      lt_sum = lt_sum - LT_MOD;
    end
  end

  // Month length and day of year.
  always_comb begin
    if (month_r <= 4'd6) begin
      mlen = 5'd31;
    end else if (month_r <= 4'd11) begin
      mlen = 5'd30;
    end else begin
      mlen = lp_r ? 5'd30 : 5'd29;
    end
  end
  assign off_c = days_before(month_r) + OFF_W'(day_r);
  assign f_c   = mod7_small({1'b0, bm_r} + 4'd4);

  // Shared divide-by-seven unit: week offset first, then day of year.
  assign div_in   = (state_r == ST_WEEK) ? x_r : off_r;
  assign div_q    = div7(div_in);
  assign rem_full = off_r - ((div_q << 3) - div_q);

  // Weekday and 53-week tests of this year and the previous one.
  assign wd_idx   = mod7_small({1'b0, mod7_small({1'b0, bm_r} + {1'b0, rem_full[2:0]})}
                               + 4'd3);
  assign fp       = mod7_small({1'b0, bm_prev_r} + 4'd4);
  assign w53_cur  = (f_r == WD_THU) || (lp_r && (f_r == WD_THU - 3'd1));
  assign w53_prev = (fp == WD_THU) || (lp_prev_r && (fp == WD_THU - 3'd1));

  // Week carried into the neighboring year where needed.
  always_comb begin
    week_f  = wraw_r;
    wyear_f = {1'b0, year_r};
    if (wraw_r == '0) begin
      if (year_r == YEAR_W'(1)) begin
        week_f  = WEEKS_BASE;
        wyear_f = '0;
      end else begin
        week_f  = WEEKS_BASE + WEEK_W'(w53_prev);
        wyear_f = {1'b0, year_r} - WYEAR_W'(1);
      end
    end else if (wraw_r > (WEEKS_BASE + WEEK_W'(w53_cur))) begin
      week_f  = WEEK_W'(1);
      wyear_f = {1'b0, year_r} + WYEAR_W'(1);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_year == '0) || ({1'b0, in_year} > (YEAR_W + 1)'(MAX_YEAR)) ||
              (in_month == '0) || (in_month > 4'd12)) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_LOOP;
          end
        end
      end
      ST_LOOP: begin
        if (cnt_r == year_r) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK:  state_nxt = ST_WEEK;
      ST_WEEK: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          year_r   <= in_year;
          month_r  <= in_month;
          day_r    <= in_day;
          inv_r    <= (state_nxt == ST_FIN);
          valid_r  <= 1'b0;
          cnt_r    <= YEAR_W'(1);
          e_r      <= E_INIT;
          lt_r     <= LT_INIT;
          before_r <= '0;
          bm_r     <= '0;
          bm_prev_r <= '0;
          lp_prev_r <= 1'b0;
        end
      end
      ST_LOOP: begin
        // One year per cycle: record the leap flag and the running sums.
        if (cnt_r == year_r - YEAR_W'(1)) begin
          lp_prev_r <= leap_now;
          bm_prev_r <= bm_r;
        end
        if (cnt_r == year_r) begin
          lp_r <= leap_now;
        end else begin
          before_r <= before_r + DN_W'(365) + DN_W'(leap_now);
          bm_r     <= mod7_small({1'b0, bm_r} + 4'd1 + 4'(leap_now));
          cnt_r    <= cnt_r + YEAR_W'(1);
          e_r      <= (e_r == E_LAST) ? E_FIRST : (e_r + LT_W'(1));
          lt_r     <= lt_sum;
        end
      end
      ST_CHK: begin
        valid_r <= (day_r != '0) && (day_r <= mlen);
        off_r   <= off_c;
        dn_r    <= before_r + DN_W'(off_c);
        f_r     <= f_c;
        x_r     <= off_c - OFF_W'(1) + OFF_W'(f_c);
      end
      ST_WEEK: begin
        wraw_r <= WEEK_W'(div_q) + WEEK_W'(f_r < 3'd4);
      end
      ST_FIN: begin
        if (valid_r && !inv_r) begin
          out_data_r <= {4'd0, wyear_f, week_f, wd_idx + 3'd1, dn_r, 1'b1};
        end else begin
          out_data_r <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
